// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// No dependencies; every other file of the block but tcw_ram imports this package.
package tcw_pkg;

  // Default screen geometry
  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  // Cell address width, wide enough for up to 128 x 64 cells
  localparam int CELL_ADDR_W = 13;

  // Character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [3:0] LIGHT_GREY = 4'h7;
  localparam int         TAB_STEP   = 4;
  localparam logic [7:0] TEXT_COLOR_RESET = {4'h0, LIGHT_GREY};
  localparam logic [15:0] RESET_BLANK = {TEXT_COLOR_RESET, CH_SPACE};

  // Request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Command kinds handed from front to back
  localparam logic [1:0] CMD_NOP   = 2'd0;
  localparam logic [1:0] CMD_PUT   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [3:0] clear_background;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } tcw_in_t;

  typedef struct packed {
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic       scrolled;
    logic [7:0] read_char;
    logic [7:0] read_color;
  } tcw_out_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   do_write;
    logic                   do_scroll;
    logic [CELL_ADDR_W-1:0] addr;
    logic [15:0]            cell_data;
    logic [7:0]             fill_attr;
    logic [4:0]             cursor_row;
    logic [6:0]             cursor_col;
  } tcw_cmd_t;

endpackage

// ===== rtl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back (and tcw_ram through it).
//
// Text console writer. Keeps a ROWS x COLUMNS screen of 16-bit cells (low
// byte character, high byte attribute) plus a cursor. A request is taken at
// a clock edge where start is high and busy is low; mode selects put
// character, clear screen or read one cell. Every request yields exactly one
// result, shown on out_item for a single cycle with out_strobe high; the
// receiver cannot hold results off, so it must take each one as it appears.
// Results come out in request order. After reset the block runs a clearing
// pass over all COLUMNS*ROWS cells of screen memory (2000 by default), one
// cell per cycle, with busy high. A plain put, a control code or an ignored
// request is finished in the back end's idle state, which registers its
// result as it takes the command from the queue; a read passes through a
// further state for the registered memory read. A put that scrolls keeps
// the back end busy for a row copy through the single read and write port,
// then for filling the bottom row, and a clear fills every cell. A
// two-deep command queue lets up to two further requests be taken while the
// back end is working; busy rises when it is full. The text_color register
// is written through cfg_wr_en/cfg_wr_data and should change only while no
// request is outstanding.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::tcw_in_t  in_item,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  output logic              out_strobe,
  output tcw_pkg::tcw_out_t out_item
);
  import tcw_pkg::*;

  logic     accept;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  logic     init_busy;
  tcw_cmd_t front_cmd;
  tcw_cmd_t head_cmd;

  // No requests during the power-up clearing pass or while the queue is full
  assign busy   = q_full | init_busy;
  assign accept = start & ~busy;

  // Front end: cursor tracking, classification, cell address math
  tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (front_cmd)
  );

  // Decouples the front end from long scroll and clear passes
  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_cmd   (front_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: screen memory, scroll/clear sequencer, result register
  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .pop        (q_pop),
    .init_busy  (init_busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/tcw_front.sv =====
`timescale 1ns / 1ps
// Front end: holds cursor and text color, classifies each request into a command.
// Depends on tcw_pkg.
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  tcw_pkg::tcw_in_t   in_item,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  output tcw_pkg::tcw_cmd_t  cmd
);
  import tcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);

  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [7:0]    text_color_r;

  logic [RW:0]   row_e;
  logic [CW:0]   col_e;
  logic          put_write;
  logic          put_scroll;
  logic [RW-1:0] wr_row;
  logic [CW-1:0] wr_col;
  logic [7:0]    wr_char;
  logic [CELL_ADDR_W-1:0] wr_addr;
  logic [CELL_ADDR_W-1:0] rd_addr;
  logic          rd_in_range;
  logic [RW-1:0] row_after;
  logic [CW-1:0] col_after;
  logic [31:0]   row_w;
  logic [31:0]   col_w;

  // Cursor motion for put mode
  always_comb begin
    row_e      = {1'b0, row_r};
    col_e      = {1'b0, col_r};
    put_write  = 1'b0;
    put_scroll = 1'b0;
    wr_row     = row_r;
    wr_col     = col_r;
    wr_char    = in_item.char_code;
    case (in_item.char_code)
      CH_NEWLINE: begin
        row_e = row_e + 1'b1;
        col_e = '0;
      end
      CH_TAB: begin
        col_e = (col_e + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_STEP - 1));
      end
      CH_RETURN: begin
        col_e = '0;
      end
      CH_BACKSPACE: begin
        if (col_r != '0) begin
          col_e = col_e - 1'b1;
        end else if (row_r != '0) begin
          row_e = row_e - 1'b1;
          col_e = (CW+1)'(COLUMNS - 1);
        end
        put_write = 1'b1;
        wr_row    = row_e[RW-1:0];
        wr_col    = col_e[CW-1:0];
        wr_char   = CH_SPACE;
      end
      default: begin
        put_write = 1'b1;
        col_e     = col_e + 1'b1;
      end
    endcase
    if (col_e >= (CW+1)'(COLUMNS)) begin
      col_e = '0;
      row_e = row_e + 1'b1;
    end
    if (row_e >= (RW+1)'(ROWS)) begin
      put_scroll = 1'b1;
      row_e      = (RW+1)'(ROWS - 1);
    end
  end

  assign wr_addr = CELL_ADDR_W'(wr_row) * CELL_ADDR_W'(COLUMNS) + CELL_ADDR_W'(wr_col);
  assign rd_addr = CELL_ADDR_W'(in_item.cell_row) * CELL_ADDR_W'(COLUMNS)
                 + CELL_ADDR_W'(in_item.cell_col);
  assign rd_in_range = (32'(in_item.cell_row) < ROWS) && (32'(in_item.cell_col) < COLUMNS);

  always_comb begin
    cmd       = '0;
    cmd.kind  = CMD_NOP;
    row_after = row_r;
    col_after = col_r;
    case (in_item.mode)
      MODE_PUT: begin
        cmd.kind      = CMD_PUT;
        cmd.do_write  = put_write;
        cmd.do_scroll = put_scroll;
        cmd.addr      = wr_addr;
        cmd.cell_data = {text_color_r, wr_char};
        cmd.fill_attr = text_color_r;
        row_after     = row_e[RW-1:0];
        col_after     = col_e[CW-1:0];
      end
      MODE_CLEAR: begin
        cmd.kind      = CMD_CLEAR;
        cmd.cell_data = {in_item.clear_background, LIGHT_GREY, CH_SPACE};
        row_after     = '0;
        col_after     = '0;
      end
      MODE_READ: begin
        if (rd_in_range) begin
          cmd.kind = CMD_READ;
          cmd.addr = rd_addr;
        end
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
    row_w          = 32'(row_after);
    col_w          = 32'(col_after);
    cmd.cursor_row = row_w[4:0];
    cmd.cursor_col = col_w[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      text_color_r <= TEXT_COLOR_RESET;
    end else begin
      if (cfg_wr_en) begin
        text_color_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_item.mode == MODE_PUT) begin
          row_r <= row_e[RW-1:0];
          col_r <= col_e[CW-1:0];
        end else if (in_item.mode == MODE_CLEAR) begin
          row_r <= '0;
          col_r <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/tcw_queue.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between front and back end.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output tcw_pkg::tcw_cmd_t head_cmd
);
  import tcw_pkg::*;

  tcw_cmd_t   entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
`timescale 1ns / 1ps
// Back end: executes commands against screen memory and strobes results.
// Depends on tcw_pkg and tcw_ram.
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tcw_pkg::tcw_cmd_t q_cmd,
  output logic              pop,
  output logic              init_busy,
  output logic              out_strobe,
  output tcw_pkg::tcw_out_t out_item
);
  import tcw_pkg::*;

  localparam int TOTAL  = COLUMNS * ROWS;
  localparam int COPY_N = COLUMNS * (ROWS - 1);
  localparam int AW     = $clog2(TOTAL);
  localparam int CNT_W  = $clog2(TOTAL + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tcw_cmd_t         cmd_r, cmd_nxt;
  logic [15:0]      fill_r, fill_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  tcw_out_t         out_item_r, out_item_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [15:0]      wdata;
  logic [AW-1:0]    raddr;
  logic [15:0]      rdata;
  logic [CNT_W-1:0] src_idx;
  logic [CNT_W-1:0] dst_idx;

  tcw_ram #(.WIDTH(16), .DEPTH(TOTAL)) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign src_idx = cnt_r + CNT_W'(COLUMNS);
  assign dst_idx = cnt_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    fill_nxt       = fill_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    pop            = 1'b0;
    we             = 1'b0;
    waddr          = cnt_r[AW-1:0];
    wdata          = fill_r;
    raddr          = src_idx[AW-1:0];
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = RESET_BLANK;
        if (cnt_r == CNT_W'(TOTAL - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          cmd_nxt = q_cmd;
          cnt_nxt = '0;
          out_item_nxt                = '0;
          out_item_nxt.cursor_row_out = q_cmd.cursor_row;
          out_item_nxt.cursor_col_out = q_cmd.cursor_col;
          case (q_cmd.kind)
            CMD_PUT: begin
              we    = q_cmd.do_write;
              waddr = q_cmd.addr[AW-1:0];
              wdata = q_cmd.cell_data;
              if (q_cmd.do_scroll) begin
                state_nxt = S_SCROLL;
                fill_nxt  = {q_cmd.fill_attr, CH_SPACE};
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            CMD_CLEAR: begin
              state_nxt = S_FILL;
              fill_nxt  = q_cmd.cell_data;
            end
            CMD_READ: begin
              raddr     = q_cmd.addr[AW-1:0];
              state_nxt = S_READ;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_strobe_nxt          = 1'b1;
        out_item_nxt.read_char  = rdata[7:0];
        out_item_nxt.read_color = rdata[15:8];
        state_nxt               = S_IDLE;
      end
      S_SCROLL: begin
        // read one row below, write back the word fetched last cycle
        if (cnt_r != '0) begin
          we    = 1'b1;
          waddr = dst_idx[AW-1:0];
          wdata = rdata;
        end
        if (cnt_r == CNT_W'(COPY_N)) begin
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (cnt_r == CNT_W'(TOTAL - 1)) begin
          state_nxt              = S_IDLE;
          out_strobe_nxt         = 1'b1;
          out_item_nxt.scrolled  = cmd_r.do_scroll;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    fill_r     <= fill_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign init_busy  = (state_r == S_INIT);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
